FILE: rtl/timestamp_sorted_event_queue_defines.svh
// Assertion macros used by the event queue checker.
`ifndef TIMESTAMP_SORTED_EVENT_QUEUE_DEFINES_SVH
`define TIMESTAMP_SORTED_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TSEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TSEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tseq_pkg.sv
// Types and constants of the timestamp sorted event queue.
package tseq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TIME_W      = 48;
  localparam int OCC_W       = 7;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_DROPPED  = 2'd1;
  localparam logic [1:0] STATUS_DUE      = 2'd2;
  localparam logic [1:0] STATUS_NONE_DUE = 2'd3;

  typedef struct packed {
    logic               action;
    logic [TIME_W-1:0]  event_time;
    logic [6:0]         note;
    logic [1:0]         voice_kind;
    logic [22:0]        duration_ticks;
    logic [15:0]        level;
    logic signed [15:0] pan_pos;
  } tseq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TIME_W-1:0]  out_time;
    logic [6:0]         out_note;
    logic [1:0]         out_kind;
    logic [22:0]        out_duration;
    logic [15:0]        out_level;
    logic signed [15:0] out_pan;
    logic [OCC_W-1:0]   occupancy;
    logic               last_of_run;
  } tseq_out_t;

  // One stored event.
  typedef struct packed {
    logic [TIME_W-1:0]  event_time;
    logic [6:0]         note;
    logic [1:0]         voice_kind;
    logic [22:0]        duration_ticks;
    logic [15:0]        level;
    logic signed [15:0] pan_pos;
  } tseq_entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic        ins;
    logic        pop;
    tseq_entry_t new_entry;
  } tseq_ctrl_t;

endpackage

FILE: rtl/timestamp_sorted_event_queue.sv
// Timestamp sorted event queue: a chain of cells kept in ascending time order.
// Insert: its single result is registered at the next edge.
// Release: the deadline is registered, then one due event per cycle from the head
//   while the output register is free, by the pop shift; none due: one marked result.
// Reset (async, active low) empties the queue and the output register; cell
//   contents are left as they are and only slots below the count are ever read.
module timestamp_sorted_event_queue #(
  parameter int QueueDepth = tseq_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tseq_pkg::tseq_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tseq_pkg::tseq_out_t out_data_o
);
  import tseq_pkg::*;

  localparam int CntW = $clog2(QueueDepth + 1);

  typedef enum logic {
    S_IDLE,
    S_RELEASE
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [TIME_W-1:0] deadline_q;
  logic              out_valid_q;
  tseq_out_t         out_q;
  tseq_out_t         res_d;

  tseq_ctrl_t  ctrl;
  tseq_entry_t cell_entry [QueueDepth];
  logic        cell_gt    [QueueDepth];
  logic        cell_occ   [QueueDepth];

  logic slot_free, in_fire, full, due0, due1, ins_go, pop_go, load_res, last_pop;
  logic [CntW-1:0] count_inc, count_dec;

  // Output register frees up in the same cycle its transfer completes.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(QueueDepth));
  assign count_inc  = count_q + CntW'(1);
  assign count_dec  = count_q - CntW'(1);

  // Head is due, and whether the one behind it is due too (if not, this pop ends the run).
  assign due0     = (count_q != '0) && (cell_entry[0].event_time <= deadline_q);
  assign due1     = (count_q > CntW'(1)) && (cell_entry[1].event_time <= deadline_q);
  assign last_pop = !due1;

  assign ins_go = in_fire && (in_data_i.action == ACT_INSERT) && !full;
  assign pop_go = (state_q == S_RELEASE) && slot_free && due0;

  assign ctrl.ins                      = ins_go;
  assign ctrl.pop                      = pop_go;
  assign ctrl.new_entry.event_time     = in_data_i.event_time;
  assign ctrl.new_entry.note           = in_data_i.note;
  assign ctrl.new_entry.voice_kind     = in_data_i.voice_kind;
  assign ctrl.new_entry.duration_ticks = in_data_i.duration_ticks;
  assign ctrl.new_entry.level          = in_data_i.level;
  assign ctrl.new_entry.pan_pos        = in_data_i.pan_pos;

  // The chain: slot 0 is the head. Later events shift right on insert,
  // everything shifts left on pop.
  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    tseq_entry_t left_e, right_e;
    logic        left_gt;

    assign cell_occ[g] = (count_q > CntW'(g));

    if (g == 0) begin : g_head
      assign left_e  = cell_entry[g];
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_e  = cell_entry[g-1];
      assign left_gt = cell_gt[g-1];
    end

    if (g == QueueDepth - 1) begin : g_tail
      assign right_e = cell_entry[g];
    end else begin : g_mid
      assign right_e = cell_entry[g+1];
    end

    tseq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .left_i    (left_e),
      .right_i   (right_e),
      .occ_i     (cell_occ[g]),
      .left_gt_i (left_gt),
      .entry_o   (cell_entry[g]),
      .gt_o      (cell_gt[g])
    );
  end

  // Build the next result and decide whether it loads this cycle.
  always_comb begin
    res_d    = '0;
    load_res = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_data_i.action == ACT_INSERT)) begin
          load_res          = 1'b1;
          res_d.status      = full ? STATUS_DROPPED : STATUS_ACCEPTED;
          res_d.occupancy   = full ? OCC_W'(count_q) : OCC_W'(count_inc);
          res_d.last_of_run = 1'b1;
        end
      end
      S_RELEASE: begin
        if (slot_free) begin
          load_res = 1'b1;
          if (due0) begin
            res_d.status       = STATUS_DUE;
            res_d.out_time     = cell_entry[0].event_time;
            res_d.out_note     = cell_entry[0].note;
            res_d.out_kind     = cell_entry[0].voice_kind;
            res_d.out_duration = cell_entry[0].duration_ticks;
            res_d.out_level    = cell_entry[0].level;
            res_d.out_pan      = cell_entry[0].pan_pos;
            res_d.occupancy    = OCC_W'(count_dec);
            res_d.last_of_run  = last_pop;
          end else begin
            // Nothing due at all: single marked result.
            res_d.status      = STATUS_NONE_DUE;
            res_d.occupancy   = OCC_W'(count_q);
            res_d.last_of_run = 1'b1;
          end
        end
      end
      default: begin
        load_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      deadline_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (load_res) begin
        out_valid_q <= 1'b1;
        out_q       <= res_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (ins_go) begin
            count_q <= count_inc;
          end
          if (in_fire && (in_data_i.action == ACT_RELEASE)) begin
            deadline_q <= in_data_i.event_time;
            state_q    <= S_RELEASE;
          end
        end
        S_RELEASE: begin
          if (slot_free) begin
            if (due0) begin
              count_q <= count_dec;
              if (last_pop) begin
                state_q <= S_IDLE;
              end
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/tseq_cell.sv
// One slot of the sorted chain: holds an event, shifts right on insert, left on pop.
module tseq_cell (
  input  logic                 clk_i,
  input  tseq_pkg::tseq_ctrl_t  ctrl_i,
  input  tseq_pkg::tseq_entry_t left_i,
  input  tseq_pkg::tseq_entry_t right_i,
  input  logic                 occ_i,
  input  logic                 left_gt_i,
  output tseq_pkg::tseq_entry_t entry_o,
  output logic                 gt_o
);
  import tseq_pkg::*;

  tseq_entry_t entry_q, entry_d;

  // Stored event is later than the incoming one: it must move right.
  assign gt_o = occ_i && (entry_q.event_time > ctrl_i.new_entry.event_time);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (left_gt_i) begin
        entry_d = left_i;
      end else if (gt_o || !occ_i) begin
        entry_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/tseq_checker.sv
// Port-level assertions for the event queue, bound to the top level.
`include "timestamp_sorted_event_queue_defines.svh"

module tseq_checker #(
  parameter int QueueDepth = tseq_pkg::QUEUE_DEPTH
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input tseq_pkg::tseq_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tseq_pkg::tseq_out_t out_data_o
);
  import tseq_pkg::*;

  logic stalled;
  logic ins_res;
  logic drop_res;
  logic over_depth;

  assign stalled    = out_valid_o && !out_ready_i;
  assign ins_res    = out_valid_o && ((out_data_o.status == STATUS_ACCEPTED) ||
                                      (out_data_o.status == STATUS_DROPPED));
  assign drop_res   = out_valid_o && (out_data_o.status == STATUS_DROPPED);
  assign over_depth = (int'(out_data_o.occupancy) > QueueDepth);

  // Hold a stalled result unchanged.
  `TSEQ_ASSERT_NEXT(a_out_hold, stalled, out_valid_o && $stable(out_data_o),
                    "stalled result changed")

  // Insert results end their run and carry no event.
  `TSEQ_ASSERT_NOW(a_ins_last, ins_res,
                   out_data_o.last_of_run && (out_data_o.out_time == '0),
                   "bad insert result")

  // Drop only when the queue is full.
  `TSEQ_ASSERT_NOW(a_drop_full, drop_res, int'(out_data_o.occupancy) == QueueDepth,
                   "drop while not full")

  // Never report more events than slots.
  `TSEQ_ASSERT_NOW(a_occ_bound, out_valid_o, !over_depth, "occupancy above depth")

  // A run that is not finished blocks new input.
  `TSEQ_ASSERT_NOW(a_run_blocks, out_valid_o && !out_data_o.last_of_run, !in_ready_o,
                   "input taken mid run")

endmodule

bind timestamp_sorted_event_queue tseq_checker #(.QueueDepth(QueueDepth)) u_tseq_checker (.*);
